### rtl/htok_pkg.sv
// Shared types, constants and character-class functions for the HTML tokenizer.
`default_nettype none
package htok_pkg;

  localparam int CMD_DEPTH_DEF = 2;
  localparam int OUT_DEPTH_DEF = 2;

  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_DQ    = 8'h22;
  localparam logic [7:0] CH_SQ    = 8'h27;

  localparam logic [3:0] KIND_TEXT       = 4'd0;
  localparam logic [3:0] KIND_TEXTEND    = 4'd1;
  localparam logic [3:0] KIND_TAGNAME    = 4'd2;
  localparam logic [3:0] KIND_ATTRNAME   = 4'd3;
  localparam logic [3:0] KIND_ATTRVALUE  = 4'd4;
  localparam logic [3:0] KIND_ATTREND    = 4'd5;
  localparam logic [3:0] KIND_TAGEND     = 4'd6;
  localparam logic [3:0] KIND_DOCTYPE    = 4'd7;
  localparam logic [3:0] KIND_DOCTYPEEND = 4'd8;
  localparam logic [3:0] KIND_ERROR      = 4'd9;
  localparam logic [3:0] KIND_INCOMPLETE = 4'd10;

  localparam logic [2:0] DOC_LEN = 3'd7;

  // Result slots of one item, emitted lowest first.
  localparam int NSLOTS = 13;
  localparam int SLOT_W = 4;
  localparam logic [SLOT_W-1:0] SLOT_REP_LO = 4'd0;
  localparam logic [SLOT_W-1:0] SLOT_REP_HI = 4'd5;
  localparam logic [SLOT_W-1:0] SLOT_PRE_TE = 4'd6;
  localparam logic [SLOT_W-1:0] SLOT_PRE_AE = 4'd7;
  localparam logic [SLOT_W-1:0] SLOT_MAIN   = 4'd8;
  localparam logic [SLOT_W-1:0] SLOT_TAGEND = 4'd9;
  localparam logic [SLOT_W-1:0] SLOT_END_TE = 4'd10;
  localparam logic [SLOT_W-1:0] SLOT_END_AE = 4'd11;
  localparam logic [SLOT_W-1:0] SLOT_END_IN = 4'd12;

  typedef enum logic [3:0] {
    MODE_DATA    = 4'd0,
    MODE_LT      = 4'd1,
    MODE_BANG    = 4'd2,
    MODE_DOCTYPE = 4'd3,
    MODE_SLASH   = 4'd4,
    MODE_NAME    = 4'd5,
    MODE_ATTR    = 4'd6,
    MODE_EQ      = 4'd7,
    MODE_QUOTED  = 4'd8,
    MODE_BARE    = 4'd9
  } mode_t;

  typedef struct packed {
    logic [NSLOTS-1:0] mask;
    logic [3:0]        main_kind;
    logic [7:0]        main_ch;
    logic              end_tag;
    logic              self_close;
  } cmd_t;

  typedef struct packed {
    logic [3:0] kind;
    logic [7:0] ch_out;
    logic       end_tag;
    logic       self_closing;
    logic       run_last;
  } res_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    return is_alpha(c) || (c >= 8'h30 && c <= 8'h39);
  endfunction

  function automatic logic [7:0] doc_char(input logic [2:0] idx);
    logic [7:0] r;
    case (idx)
      3'd0:    r = 8'h44;
      3'd1:    r = 8'h4F;
      3'd2:    r = 8'h43;
      3'd3:    r = 8'h54;
      3'd4:    r = 8'h59;
      3'd5:    r = 8'h50;
      3'd6:    r = 8'h45;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

### rtl/html_markup_tokenizer.sv
// HTML markup tokenizer: a byte stream in, a stream of classified markup events out.
//
// Input queue port: one markup byte (in_ch) with an end-of-document mark (in_last) is
// taken at each edge where in_push is high and in_full is low. Each byte gives zero to
// eight events; every event of a byte comes out in order and the last one carries
// out_run_last. Events wait on the out_ ports while out_empty is low and are taken on
// an edge with out_pop high.
// Throughput while the output queue has room: one byte per cycle as long as bytes give
// at most one event each. The back end emits one event per cycle, so a byte with more
// events holds it until all are out; the queue between front and back absorbs this and
// in_full rises only when it fills.
// The end-of-document mark closes open runs and returns the tokenizer to its reset state.
// Reset (rst_n low, synchronous) empties both queues and puts the tokenizer in text
// mode; bytes are taken from the first cycle after reset.
// When the receiver stalls, the output queue fills, the back end halts, and in_full
// rises once the command queue is full; nothing is dropped.
`default_nettype none
module html_markup_tokenizer
  import htok_pkg::*;
#(
  parameter int CMD_DEPTH = CMD_DEPTH_DEF,
  parameter int OUT_DEPTH = OUT_DEPTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_push,
  input  wire logic [7:0] in_ch,
  input  wire logic       in_last,
  output logic            in_full,
  output logic            out_empty,
  input  wire logic       out_pop,
  output logic [3:0]      out_kind,
  output logic [7:0]      out_ch_out,
  output logic            out_end_tag,
  output logic            out_self_closing,
  output logic            out_run_last
);

  logic cq_push, cq_full, cq_pop, cq_empty;
  cmd_t cq_wdata, cq_rdata;
  logic oq_push, oq_full;
  res_t oq_wdata, oq_rdata;

  htok_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_ch   (in_ch),
    .in_last (in_last),
    .in_full (in_full),
    .cq_push (cq_push),
    .cq_data (cq_wdata),
    .cq_full (cq_full)
  );

  htok_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cq_push),
    .wdata (cq_wdata),
    .full  (cq_full),
    .pop   (cq_pop),
    .rdata (cq_rdata),
    .empty (cq_empty)
  );

  htok_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cq_data  (cq_rdata),
    .cq_empty (cq_empty),
    .cq_pop   (cq_pop),
    .oq_push  (oq_push),
    .oq_data  (oq_wdata),
    .oq_full  (oq_full)
  );

  htok_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (oq_push),
    .wdata (oq_wdata),
    .full  (oq_full),
    .pop   (out_pop),
    .rdata (oq_rdata),
    .empty (out_empty)
  );

  assign out_kind         = oq_rdata.kind;
  assign out_ch_out       = oq_rdata.ch_out;
  assign out_end_tag      = oq_rdata.end_tag;
  assign out_self_closing = oq_rdata.self_closing;
  assign out_run_last     = oq_rdata.run_last;

endmodule
`default_nettype wire

### rtl/htok_fifo.sv
// Small register queue with registered count, used between and after the two halves.
`default_nettype none
module htok_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rdata,
  output logic                  empty
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule
`default_nettype wire

### rtl/htok_front.sv
// Front end: takes input bytes, runs the tokenizer state and builds a slot command per item.
`default_nettype none
module htok_front
  import htok_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_push,
  input  wire logic [7:0] in_ch,
  input  wire logic       in_last,
  output logic            in_full,
  output logic            cq_push,
  output cmd_t            cq_data,
  input  wire logic       cq_full
);

  mode_t      mode_r, mode_nxt, mode_step;
  logic [2:0] match_r, match_nxt, match_step;
  logic       quote_r, quote_nxt, quote_step;
  logic       text_r, text_nxt, text_step;
  logic       attr_r, attr_nxt, attr_step;
  logic       tend_r, tend_nxt, tend_step;
  logic       self_r, self_nxt, self_step;
  logic       accept;
  logic       c_space, c_alpha, c_alnum, doc_hit, quote_hit;
  cmd_t       cmd;

  assign c_space   = is_space(in_ch);
  assign c_alpha   = is_alpha(in_ch);
  assign c_alnum   = is_alnum(in_ch);
  assign doc_hit   = (match_r != DOC_LEN) && (in_ch == doc_char(match_r));
  assign quote_hit = (in_ch == (quote_r ? CH_SQ : CH_DQ));
  assign accept    = in_push && !cq_full;
  assign in_full   = cq_full;

  // Next state for one byte, before end-of-document handling.
  always_comb begin
    mode_step  = mode_r;
    match_step = match_r;
    quote_step = quote_r;
    text_step  = text_r;
    attr_step  = attr_r;
    tend_step  = tend_r;
    self_step  = self_r;
    unique case (mode_r)
      MODE_LT: begin
        if (in_ch == CH_BANG) begin
          match_step = '0;
          mode_step  = MODE_BANG;
        end else if (in_ch == CH_SLASH) begin
          mode_step = MODE_SLASH;
        end else if (c_alpha) begin
          mode_step = MODE_NAME;
        end else begin
          mode_step = MODE_DATA;
        end
      end
      MODE_SLASH: begin
        if (c_alpha) begin
          tend_step = 1'b1;
          mode_step = MODE_NAME;
        end else begin
          mode_step = MODE_DATA;
        end
      end
      MODE_BANG: begin
        if (doc_hit) begin
          if (match_r == DOC_LEN - 3'd1) begin
            match_step = '0;
            mode_step  = MODE_DOCTYPE;
          end else begin
            match_step = match_r + 3'd1;
          end
        end else begin
          match_step = '0;
          if (in_ch == CH_LT) begin
            text_step = 1'b0;
            tend_step = 1'b0;
            self_step = 1'b0;
            attr_step = 1'b0;
            mode_step = MODE_LT;
          end else begin
            text_step = 1'b1;
            mode_step = MODE_DATA;
          end
        end
      end
      MODE_DOCTYPE: begin
        if (!c_alnum && in_ch == CH_GT) begin
          mode_step = MODE_DATA;
        end
      end
      MODE_NAME: begin
        if (c_alnum) begin
          mode_step = MODE_NAME;
        end else if (c_space) begin
          mode_step = MODE_ATTR;
        end else if (in_ch == CH_GT) begin
          mode_step = MODE_DATA;
        end else if (in_ch == CH_SLASH) begin
          self_step = 1'b1;
          mode_step = MODE_ATTR;
        end
      end
      MODE_ATTR: begin
        if (c_alnum || in_ch == CH_DASH) begin
          attr_step = 1'b1;
        end else if (in_ch == CH_EQ) begin
          attr_step = 1'b1;
          mode_step = MODE_EQ;
        end else if (c_space) begin
          attr_step = 1'b0;
        end else if (in_ch == CH_GT) begin
          attr_step = 1'b0;
          mode_step = MODE_DATA;
        end else if (in_ch == CH_SLASH) begin
          attr_step = 1'b0;
          self_step = 1'b1;
        end
      end
      MODE_EQ: begin
        if (in_ch == CH_DQ || in_ch == CH_SQ) begin
          quote_step = (in_ch == CH_SQ);
          mode_step  = MODE_QUOTED;
        end else if (!c_space && in_ch != CH_GT) begin
          mode_step = MODE_BARE;
        end else begin
          mode_step = MODE_ATTR;
        end
      end
      MODE_QUOTED: begin
        if (quote_hit) begin
          attr_step = 1'b0;
          mode_step = MODE_ATTR;
        end
      end
      MODE_BARE: begin
        if (in_ch == CH_GT) begin
          attr_step = 1'b0;
          mode_step = MODE_DATA;
        end else if (c_space) begin
          attr_step = 1'b0;
          mode_step = MODE_ATTR;
        end
      end
      default: begin
        mode_step = MODE_DATA;
        if (in_ch == CH_LT) begin
          text_step = 1'b0;
          tend_step = 1'b0;
          self_step = 1'b0;
          attr_step = 1'b0;
          mode_step = MODE_LT;
        end else begin
          text_step = 1'b1;
        end
      end
    endcase
  end

  always_comb begin
    mode_nxt  = mode_r;
    match_nxt = match_r;
    quote_nxt = quote_r;
    text_nxt  = text_r;
    attr_nxt  = attr_r;
    tend_nxt  = tend_r;
    self_nxt  = self_r;
    if (accept) begin
      if (in_last) begin
        mode_nxt  = MODE_DATA;
        match_nxt = '0;
        quote_nxt = 1'b0;
        text_nxt  = 1'b0;
        attr_nxt  = 1'b0;
        tend_nxt  = 1'b0;
        self_nxt  = 1'b0;
      end else begin
        mode_nxt  = mode_step;
        match_nxt = match_step;
        quote_nxt = quote_step;
        text_nxt  = text_step;
        attr_nxt  = attr_step;
        tend_nxt  = tend_step;
        self_nxt  = self_step;
      end
    end
  end

  // Slot command for one byte.
  always_comb begin
    cmd            = '0;
    cmd.main_ch    = in_ch;
    cmd.end_tag    = tend_r;
    cmd.self_close = self_r;
    unique case (mode_r)
      MODE_LT: begin
        if (in_ch != CH_BANG && in_ch != CH_SLASH) begin
          cmd.mask[SLOT_MAIN] = 1'b1;
          cmd.main_kind       = c_alpha ? KIND_TAGNAME : KIND_ERROR;
        end
      end
      MODE_SLASH: begin
        cmd.mask[SLOT_MAIN] = 1'b1;
        cmd.main_kind       = c_alpha ? KIND_TAGNAME : KIND_ERROR;
      end
      MODE_BANG: begin
        if (!doc_hit) begin
          for (int i = 0; i <= int'(SLOT_REP_HI); i++) begin
            cmd.mask[i] = (3'(i) < match_r);
          end
          if (in_ch == CH_LT) begin
            cmd.mask[SLOT_PRE_TE] = text_r || (match_r != '0);
          end else begin
            cmd.mask[SLOT_MAIN] = 1'b1;
            cmd.main_kind       = KIND_TEXT;
          end
        end
      end
      MODE_DOCTYPE: begin
        cmd.mask[SLOT_MAIN] = 1'b1;
        if (c_alnum) begin
          cmd.main_kind = KIND_DOCTYPE;
        end else if (in_ch == CH_GT) begin
          cmd.main_kind = KIND_DOCTYPEEND;
          cmd.main_ch   = '0;
        end else begin
          cmd.main_kind = KIND_ERROR;
        end
      end
      MODE_NAME: begin
        if (c_alnum) begin
          cmd.mask[SLOT_MAIN] = 1'b1;
          cmd.main_kind       = KIND_TAGNAME;
        end else if (in_ch == CH_GT) begin
          cmd.mask[SLOT_TAGEND] = 1'b1;
        end else if (!c_space && in_ch != CH_SLASH) begin
          cmd.mask[SLOT_MAIN] = 1'b1;
          cmd.main_kind       = KIND_ERROR;
        end
      end
      MODE_ATTR: begin
        if (c_alnum || in_ch == CH_DASH) begin
          cmd.mask[SLOT_MAIN] = 1'b1;
          cmd.main_kind       = KIND_ATTRNAME;
        end else if (in_ch == CH_EQ) begin
          cmd.mask = '0;
        end else if (c_space || in_ch == CH_SLASH) begin
          cmd.mask[SLOT_PRE_AE] = attr_r;
        end else if (in_ch == CH_GT) begin
          cmd.mask[SLOT_PRE_AE] = attr_r;
          cmd.mask[SLOT_TAGEND] = 1'b1;
        end else begin
          cmd.mask[SLOT_MAIN] = 1'b1;
          cmd.main_kind       = KIND_ERROR;
        end
      end
      MODE_EQ: begin
        if (in_ch != CH_DQ && in_ch != CH_SQ) begin
          cmd.mask[SLOT_MAIN] = 1'b1;
          cmd.main_kind       = (!c_space && in_ch != CH_GT) ? KIND_ATTRVALUE : KIND_ERROR;
        end
      end
      MODE_QUOTED: begin
        if (quote_hit) begin
          cmd.mask[SLOT_PRE_AE] = attr_r;
        end else begin
          cmd.mask[SLOT_MAIN] = 1'b1;
          cmd.main_kind       = KIND_ATTRVALUE;
        end
      end
      MODE_BARE: begin
        if (in_ch == CH_GT) begin
          cmd.mask[SLOT_PRE_AE] = attr_r;
          cmd.mask[SLOT_TAGEND] = 1'b1;
        end else if (c_space) begin
          cmd.mask[SLOT_PRE_AE] = attr_r;
        end else begin
          cmd.mask[SLOT_MAIN] = 1'b1;
          cmd.main_kind       = KIND_ATTRVALUE;
        end
      end
      default: begin
        if (in_ch == CH_LT) begin
          cmd.mask[SLOT_PRE_TE] = text_r;
        end else begin
          cmd.mask[SLOT_MAIN] = 1'b1;
          cmd.main_kind       = KIND_TEXT;
        end
      end
    endcase
    if (in_last) begin
      cmd.mask[SLOT_END_TE] = text_step;
      cmd.mask[SLOT_END_AE] = attr_step;
      cmd.mask[SLOT_END_IN] = (mode_step != MODE_DATA);
    end
  end

  assign cq_data = cmd;
  assign cq_push = accept && (cmd.mask != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_DATA;
      match_r <= '0;
      quote_r <= 1'b0;
      text_r  <= 1'b0;
      attr_r  <= 1'b0;
      tend_r  <= 1'b0;
      self_r  <= 1'b0;
    end else begin
      mode_r  <= mode_nxt;
      match_r <= match_nxt;
      quote_r <= quote_nxt;
      text_r  <= text_nxt;
      attr_r  <= attr_nxt;
      tend_r  <= tend_nxt;
      self_r  <= self_nxt;
    end
  end

endmodule
`default_nettype wire

### rtl/htok_back.sv
// Back end: expands each slot command into result items, one per cycle while the output queue has room.
`default_nettype none
module htok_back
  import htok_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire cmd_t cq_data,
  input  wire logic cq_empty,
  output logic      cq_pop,
  output logic      oq_push,
  output res_t      oq_data,
  input  wire logic oq_full
);

  cmd_t              cur_r, cur_nxt;
  logic              cur_v_r, cur_v_nxt;
  logic [SLOT_W-1:0] idx;
  logic [NSLOTS-1:0] rest;
  logic              emit, done, load;
  res_t              res;

  always_comb begin
    idx = '0;
    for (int i = NSLOTS - 1; i >= 0; i--) begin
      if (cur_r.mask[i]) begin
        idx = SLOT_W'(i);
      end
    end
    rest = cur_r.mask & ~(NSLOTS'(1) << idx);
  end

  always_comb begin
    res          = '0;
    res.run_last = (rest == '0);
    unique case (idx) inside
      [SLOT_REP_LO:SLOT_REP_HI]: begin
        res.kind   = KIND_TEXT;
        res.ch_out = doc_char(idx[2:0]);
      end
      SLOT_PRE_TE, SLOT_END_TE: res.kind = KIND_TEXTEND;
      SLOT_PRE_AE, SLOT_END_AE: res.kind = KIND_ATTREND;
      SLOT_MAIN: begin
        res.kind   = cur_r.main_kind;
        res.ch_out = cur_r.main_ch;
      end
      SLOT_TAGEND: begin
        res.kind         = KIND_TAGEND;
        res.end_tag      = cur_r.end_tag;
        res.self_closing = cur_r.self_close;
      end
      SLOT_END_IN: res.kind = KIND_INCOMPLETE;
      default:     res.kind = KIND_ERROR;
    endcase
  end

  assign emit    = cur_v_r && !oq_full;
  assign done    = emit && (rest == '0);
  assign load    = (!cur_v_r || done) && !cq_empty;
  assign cq_pop  = load;
  assign oq_push = emit;
  assign oq_data = res;

  always_comb begin
    cur_nxt   = cur_r;
    cur_v_nxt = cur_v_r;
    if (load) begin
      cur_nxt   = cq_data;
      cur_v_nxt = 1'b1;
    end else if (done) begin
      cur_v_nxt = 1'b0;
    end else if (emit) begin
      cur_nxt.mask = rest;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_v_r <= 1'b0;
    end else begin
      cur_v_r <= cur_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
  end

endmodule
`default_nettype wire

### rtl/htok_checker.sv
// Port-level checks for the tokenizer, bound to the top level.
`default_nettype none
module htok_checker
  import htok_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_empty,
  input wire logic       out_pop,
  input wire logic [3:0] out_kind,
  input wire logic [7:0] out_ch_out,
  input wire logic       out_end_tag,
  input wire logic       out_self_closing
);

  a_reset_empty: assert property (@(posedge clk) $past(!rst_n) |-> out_empty)
    else $error("events pending right after reset");

  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_kind <= KIND_INCOMPLETE))
    else $error("event kind out of range");

  a_no_char: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && (out_kind == KIND_TEXTEND || out_kind == KIND_ATTREND ||
      out_kind == KIND_TAGEND || out_kind == KIND_DOCTYPEEND ||
      out_kind == KIND_INCOMPLETE)) |-> (out_ch_out == 8'h00))
    else $error("character on an event that carries none");

  a_flags_tagend: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_kind != KIND_TAGEND) |-> (!out_end_tag && !out_self_closing))
    else $error("tag flags outside a tag end");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_kind) && $stable(out_ch_out)))
    else $error("waiting event changed");

endmodule

bind html_markup_tokenizer htok_checker u_htok_checker (.*);
`default_nettype wire
